/* src/dpla_pkg.sv */
package dpla_pkg;

   localparam int NUM_BUTTONS = 3;

   // button lane order
   localparam int BTN_START   = 0;
   localparam int BTN_DETECT  = 1;
   localparam int BTN_SPEAKER = 2;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEBOUNCE_MS   = 3'd0,
      CSR_DISTANCE_LOW  = 3'd1,
      CSR_DISTANCE_HIGH = 3'd2,
      CSR_LUX_LOW       = 3'd3,
      CSR_LUX_HIGH      = 3'd4
   } csr_index_type;

   localparam logic [7:0]  DEBOUNCE_MS_RESET   = 8'd50;
   localparam logic [15:0] DISTANCE_LOW_RESET  = 16'd200;
   localparam logic [15:0] DISTANCE_HIGH_RESET = 16'd600;
   localparam logic [15:0] LUX_LOW_RESET       = 16'd200;
   localparam logic [15:0] LUX_HIGH_RESET      = 16'd900;

   // notification modes, stepped by the detect button
   localparam logic [1:0] MODE_ALERT_SENT = 2'd0;
   localparam logic [1:0] MODE_ALERT_ONLY = 2'd1;

   typedef enum logic [1:0] {
      MSG_FINE     = 2'd0,
      MSG_DISTANCE = 2'd1,
      MSG_LIGHT    = 2'd2
   } msg_type;

   typedef enum logic [1:0] {
      TONE_NONE    = 2'd0,
      TONE_CLICK   = 2'd1,
      TONE_ALERT   = 2'd2,
      TONE_SILENCE = 2'd3
   } tone_type;

   typedef struct packed {
      logic [7:0]  debounce_ms;
      logic [15:0] distance_low;
      logic [15:0] distance_high;
      logic [15:0] lux_low;
      logic [15:0] lux_high;
   } cfg_type;

   typedef struct packed {
      logic     running;
      logic [1:0] mode;
      logic     start_pressed;
      logic     detect_pressed;
      logic     speaker_pressed;
      msg_type  message_code;
      logic     send_message;
      tone_type tone_command;
   } rsp_type;

endpackage

/* src/dpla_debounce_lane.sv */
module dpla_debounce_lane #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  raw_level,
   input  logic [TIME_WIDTH-1:0] now,
   input  logic [7:0]            debounce_ms,
   output logic                  pressed
);
   import dpla_pkg::*;

   logic                  stable_ff, stable_in;
   logic                  prev_raw_ff;
   logic [TIME_WIDTH-1:0] change_time_ff, change_time_in;
   logic [TIME_WIDTH-1:0] elapsed;
   logic                  settled;

   always_comb begin
      // a raw edge restarts the hold time
      change_time_in = (raw_level != prev_raw_ff) ? now : change_time_ff;
      elapsed        = now - change_time_in;
      settled        = elapsed > TIME_WIDTH'(debounce_ms);
      stable_in      = (settled && (raw_level != stable_ff)) ? raw_level : stable_ff;
      pressed        = settled && (raw_level != stable_ff) && raw_level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff      <= 1'b1;
         prev_raw_ff    <= 1'b1;
         change_time_ff <= '0;
      end else if (accept) begin
         stable_ff      <= stable_in;
         prev_raw_ff    <= raw_level;
         change_time_ff <= change_time_in;
      end
   end

endmodule

/* src/dpla_merge.sv */
module dpla_merge (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [dpla_pkg::NUM_BUTTONS-1:0]   pressed,
   input  logic [15:0]                        distance_mm,
   input  logic [15:0]                        light_lux,
   input  dpla_pkg::cfg_type                  cfg,
   output dpla_pkg::rsp_type                  result
);
   import dpla_pkg::*;

   logic       running_ff, running_in;
   logic [1:0] mode_ff, mode_in;
   msg_type    code;
   tone_type   tone;
   logic       send;
   logic       dist_fault, lux_fault;

   always_comb begin
      running_in = running_ff ^ pressed[BTN_START];
      mode_in    = (running_in && pressed[BTN_DETECT]) ? mode_ff + 2'd1 : mode_ff;

      dist_fault = (distance_mm < cfg.distance_low) || (distance_mm > cfg.distance_high);
      lux_fault  = (light_lux < cfg.lux_low) || (light_lux > cfg.lux_high);

      code = MSG_FINE;
      send = 1'b0;
      tone = (|pressed) ? TONE_CLICK : TONE_NONE;

      if (running_in) begin
         priority if (dist_fault) code = MSG_DISTANCE;
         else if (lux_fault)      code = MSG_LIGHT;
         else                     code = MSG_FINE;

         if (code == MSG_FINE) begin
            send = 1'b1;
         end else begin
            unique case (mode_in)
               MODE_ALERT_SENT: begin
                  send = 1'b1;
                  tone = TONE_ALERT;
               end
               MODE_ALERT_ONLY: tone = TONE_ALERT;
               default: begin
                  send = 1'b1;
                  tone = TONE_SILENCE;
               end
            endcase
         end
      end

      result.running         = running_in;
      result.mode            = mode_in;
      result.start_pressed   = pressed[BTN_START];
      result.detect_pressed  = pressed[BTN_DETECT];
      result.speaker_pressed = pressed[BTN_SPEAKER];
      result.message_code    = code;
      result.send_message    = send;
      result.tone_command    = tone;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         mode_ff    <= 2'd0;
      end else if (accept) begin
         running_ff <= running_in;
         mode_ff    <= mode_in;
      end
   end

endmodule

/* src/debounced_posture_light_alarm_core.sv */
// Debounced posture and light alarm.
// Input channel (req_): one poll per transaction with three raw button levels,
// a millisecond timestamp, a distance and a light reading. Each button has its
// own debounce lane; a merge stage toggles running, steps the mode, classifies
// the readings against the distance and lux windows and picks the tone.
// Result channel (rsp_): exactly one transaction per poll, in order.
// Each result is registered in the output register, or in the skid register when the output is held.
// Throughput: one poll per cycle while req_stall is low; the lanes and the merge
// stage are a single compare-and-select level ahead of the output register.
// A two-entry output buffer (output register plus skid register) lets one
// more poll be accepted while a result waits; req_stall rises only when both
// entries are full, and rsp_ payloads hold while rsp_stall is high.
// Configuration (csr_): registers 0..4 are debounce_ms, distance_low,
// distance_high, lux_low, lux_high; the user must write them only while idle
// (the block does not enforce it); other indexes are ignored.
// Reset (synchronous): config returns to 50/200/600/200/900, all buttons read
// released, change times zero, not running, mode 0, output buffer empty.
module debounced_posture_light_alarm_core #(
   parameter int TIME_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_start_level,
   input  logic        req_detect_level,
   input  logic        req_speaker_level,
   input  logic [31:0] req_time_ms,
   input  logic [15:0] req_distance_mm,
   input  logic [15:0] req_light_lux,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_running,
   output logic [1:0]  rsp_mode,
   output logic        rsp_start_pressed,
   output logic        rsp_detect_pressed,
   output logic        rsp_speaker_pressed,
   output logic [1:0]  rsp_message_code,
   output logic        rsp_send_message,
   output logic [1:0]  rsp_tone_command,
   input  logic        csr_write_enable,
   input  logic [dpla_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dpla_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import dpla_pkg::*;

   cfg_type cfg_ff;
   rsp_type result;
   rsp_type out_ff, skid_ff;
   logic    out_valid_ff, skid_valid_ff;
   logic    accept, out_take;

   logic [NUM_BUTTONS-1:0] raw_levels;
   logic [NUM_BUTTONS-1:0] pressed;
   logic [63:0]            time_wide;
   logic [TIME_WIDTH-1:0]  now;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;

   assign time_wide  = {32'd0, req_time_ms};
   assign now        = time_wide[TIME_WIDTH-1:0];
   assign raw_levels = {req_speaker_level, req_detect_level, req_start_level};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DEBOUNCE_MS_RESET;
         cfg_ff.distance_low  <= DISTANCE_LOW_RESET;
         cfg_ff.distance_high <= DISTANCE_HIGH_RESET;
         cfg_ff.lux_low       <= LUX_LOW_RESET;
         cfg_ff.lux_high      <= LUX_HIGH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DEBOUNCE_MS:   cfg_ff.debounce_ms   <= csr_data[7:0];
            CSR_DISTANCE_LOW:  cfg_ff.distance_low  <= csr_data;
            CSR_DISTANCE_HIGH: cfg_ff.distance_high <= csr_data;
            CSR_LUX_LOW:       cfg_ff.lux_low       <= csr_data;
            CSR_LUX_HIGH:      cfg_ff.lux_high      <= csr_data;
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      dpla_debounce_lane #(
         .TIME_WIDTH (TIME_WIDTH)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .accept      (accept),
         .raw_level   (raw_levels[i]),
         .now         (now),
         .debounce_ms (cfg_ff.debounce_ms),
         .pressed     (pressed[i])
      );
   end

   dpla_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pressed     (pressed),
      .distance_mm (req_distance_mm),
      .light_lux   (req_light_lux),
      .cfg         (cfg_ff),
      .result      (result)
   );

   // output register with skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_ff       <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_running         = out_ff.running;
   assign rsp_mode            = out_ff.mode;
   assign rsp_start_pressed   = out_ff.start_pressed;
   assign rsp_detect_pressed  = out_ff.detect_pressed;
   assign rsp_speaker_pressed = out_ff.speaker_pressed;
   assign rsp_message_code    = out_ff.message_code;
   assign rsp_send_message    = out_ff.send_message;
   assign rsp_tone_command    = out_ff.tone_command;

   // skid entry is only ever filled behind a held output
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // a stalled result stays valid and unchanged in the output register
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_ff)))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_running) |->
         (rsp_message_code == MSG_FINE && !rsp_send_message &&
          (rsp_tone_command == TONE_NONE || rsp_tone_command == TONE_CLICK)))
      else $error("classification output while not running");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_start_pressed || rsp_detect_pressed || rsp_speaker_pressed)) |->
         (rsp_tone_command != TONE_NONE))
      else $error("button press without tone");

endmodule

/* tb/posture_alarm_checker.sv */
module posture_alarm_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_start_level,
   input  logic        req_detect_level,
   input  logic        req_speaker_level,
   input  logic [31:0] req_time_ms,
   input  logic [15:0] req_distance_mm,
   input  logic [15:0] req_light_lux,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_running,
   input  logic [1:0]  rsp_mode,
   input  logic        rsp_start_pressed,
   input  logic        rsp_detect_pressed,
   input  logic        rsp_speaker_pressed,
   input  logic [1:0]  rsp_message_code,
   input  logic        rsp_send_message,
   input  logic [1:0]  rsp_tone_command,
   input  logic        csr_write_enable,
   input  logic [dpla_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dpla_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int          results_seen,
   output int          failures
);
   import dpla_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   cfg_type                cfg;
   logic [NUM_BUTTONS-1:0] stable_lv;
   logic [NUM_BUTTONS-1:0] last_raw;
   logic [31:0]            changed_at [NUM_BUTTONS];
   logic                   running_q;
   logic [1:0]             mode_q;
   rsp_type                expected_q [$];
   int                     mismatches;
   int                     seen;

   function automatic logic settle_button(int lane, logic raw, logic [31:0] now);
      logic [31:0] held;
      settle_button = 1'b0;
      if (raw != last_raw[lane]) begin
         changed_at[lane] = now;
      end
      held = now - changed_at[lane];
      if (held > {24'd0, cfg.debounce_ms} && raw != stable_lv[lane]) begin
         stable_lv[lane] = raw;
         settle_button = raw;
      end
      last_raw[lane] = raw;
   endfunction

   function automatic rsp_type predict_poll(logic [NUM_BUTTONS-1:0] raw, logic [31:0] now,
                                            logic [15:0] dist_mm, logic [15:0] lux);
      rsp_type r;
      r = '0;
      r.start_pressed   = settle_button(BTN_START, raw[BTN_START], now);
      r.detect_pressed  = settle_button(BTN_DETECT, raw[BTN_DETECT], now);
      r.speaker_pressed = settle_button(BTN_SPEAKER, raw[BTN_SPEAKER], now);
      r.tone_command = (r.start_pressed || r.detect_pressed || r.speaker_pressed) ?
                       TONE_CLICK : TONE_NONE;
      if (r.start_pressed) begin
         running_q = ~running_q;
      end
      if (running_q) begin
         if (r.detect_pressed) begin
            mode_q = mode_q + 2'd1;
         end
         // distance wins over light when both windows are violated
         if (dist_mm < cfg.distance_low || dist_mm > cfg.distance_high) begin
            r.message_code = MSG_DISTANCE;
         end else if (lux < cfg.lux_low || lux > cfg.lux_high) begin
            r.message_code = MSG_LIGHT;
         end else begin
            r.message_code = MSG_FINE;
         end
         if (r.message_code == MSG_FINE) begin
            r.send_message = 1'b1;
         end else begin
            r.send_message = (mode_q != MODE_ALERT_ONLY);
            r.tone_command = (mode_q == MODE_ALERT_SENT || mode_q == MODE_ALERT_ONLY) ?
                             TONE_ALERT : TONE_SILENCE;
         end
      end
      r.running = running_q;
      r.mode    = mode_q;
      return r;
   endfunction

   function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         cfg.debounce_ms   = DEBOUNCE_MS_RESET;
         cfg.distance_low  = DISTANCE_LOW_RESET;
         cfg.distance_high = DISTANCE_HIGH_RESET;
         cfg.lux_low       = LUX_LOW_RESET;
         cfg.lux_high      = LUX_HIGH_RESET;
         stable_lv = '1;
         last_raw  = '1;
         foreach (changed_at[i]) changed_at[i] = '0;
         running_q = 1'b0;
         mode_q    = '0;
         expected_q.delete();
         mismatches = 0;
         seen       = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen++;
            if (expected_q.size() == 0) begin
               $error("result transaction with no expectation pending");
               mismatches++;
            end else begin
               exp_r = expected_q.pop_front();
               compare_field("running", exp_r.running, rsp_running);
               compare_field("mode", exp_r.mode, rsp_mode);
               compare_field("start_pressed", exp_r.start_pressed, rsp_start_pressed);
               compare_field("detect_pressed", exp_r.detect_pressed, rsp_detect_pressed);
               compare_field("speaker_pressed", exp_r.speaker_pressed, rsp_speaker_pressed);
               compare_field("message_code", exp_r.message_code, rsp_message_code);
               compare_field("send_message", exp_r.send_message, rsp_send_message);
               compare_field("tone_command", exp_r.tone_command, rsp_tone_command);
            end
         end
         if (req_valid && !req_stall) begin
            expected_q.push_back(predict_poll({req_speaker_level, req_detect_level,
                                               req_start_level}, req_time_ms,
                                              req_distance_mm, req_light_lux));
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DEBOUNCE_MS:   cfg.debounce_ms   = csr_data[7:0];
               CSR_DISTANCE_LOW:  cfg.distance_low  = csr_data;
               CSR_DISTANCE_HIGH: cfg.distance_high = csr_data;
               CSR_LUX_LOW:       cfg.lux_low       = csr_data;
               CSR_LUX_HIGH:      cfg.lux_high      = csr_data;
               default: ;
            endcase
         end
      end
      // expectations still waiting count against the run
      results_seen <= seen;
      failures     <= mismatches + expected_q.size();
   end

endmodule

/* tb/tb_debounced_posture_light_alarm_core.sv */
module tb_debounced_posture_light_alarm_core;
   import dpla_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ALL_RELEASED  = 3'b111;
   localparam logic [2:0] PRESS_START   = 3'(1 << BTN_START);
   localparam logic [2:0] PRESS_DETECT  = 3'(1 << BTN_DETECT);
   localparam logic [2:0] PRESS_SPEAKER = 3'(1 << BTN_SPEAKER);

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_start_level;
   logic        req_detect_level;
   logic        req_speaker_level;
   logic [31:0] req_time_ms;
   logic [15:0] req_distance_mm;
   logic [15:0] req_light_lux;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_running;
   logic [1:0]  rsp_mode;
   logic        rsp_start_pressed;
   logic        rsp_detect_pressed;
   logic        rsp_speaker_pressed;
   logic [1:0]  rsp_message_code;
   logic        rsp_send_message;
   logic [1:0]  rsp_tone_command;
   logic        csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   int          results_seen;
   int          failures;
   int          polls_sent = 0;
   bit          sender_gaps = 1'b1;
   bit          receiver_stalls = 1'b1;
   logic [31:0] now_ms = '0;
   logic [2:0]  cur_levels = ALL_RELEASED;
   logic [7:0]  deb_ms = DEBOUNCE_MS_RESET;
   logic [15:0] dist_lo = DISTANCE_LOW_RESET;
   logic [15:0] dist_hi = DISTANCE_HIGH_RESET;
   logic [15:0] lux_lo = LUX_LOW_RESET;
   logic [15:0] lux_hi = LUX_HIGH_RESET;

   always #5 clock = ~clock;

   debounced_posture_light_alarm_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_start_level     (req_start_level),
      .req_detect_level    (req_detect_level),
      .req_speaker_level   (req_speaker_level),
      .req_time_ms         (req_time_ms),
      .req_distance_mm     (req_distance_mm),
      .req_light_lux       (req_light_lux),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_running         (rsp_running),
      .rsp_mode            (rsp_mode),
      .rsp_start_pressed   (rsp_start_pressed),
      .rsp_detect_pressed  (rsp_detect_pressed),
      .rsp_speaker_pressed (rsp_speaker_pressed),
      .rsp_message_code    (rsp_message_code),
      .rsp_send_message    (rsp_send_message),
      .rsp_tone_command    (rsp_tone_command),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   posture_alarm_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_start_level     (req_start_level),
      .req_detect_level    (req_detect_level),
      .req_speaker_level   (req_speaker_level),
      .req_time_ms         (req_time_ms),
      .req_distance_mm     (req_distance_mm),
      .req_light_lux       (req_light_lux),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_running         (rsp_running),
      .rsp_mode            (rsp_mode),
      .rsp_start_pressed   (rsp_start_pressed),
      .rsp_detect_pressed  (rsp_detect_pressed),
      .rsp_speaker_pressed (rsp_speaker_pressed),
      .rsp_message_code    (rsp_message_code),
      .rsp_send_message    (rsp_send_message),
      .rsp_tone_command    (rsp_tone_command),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .results_seen        (results_seen),
      .failures            (failures)
   );

   // advance the clock of the poll, hold the transaction until it is taken
   task automatic send_poll(logic [2:0] lv, logic [31:0] step, logic [15:0] dist_mm,
                            logic [15:0] lux);
      now_ms     = now_ms + step;
      cur_levels = lv;
      req_valid         <= 1'b1;
      req_start_level   <= lv[BTN_START];
      req_detect_level  <= lv[BTN_DETECT];
      req_speaker_level <= lv[BTN_SPEAKER];
      req_time_ms       <= now_ms;
      req_distance_mm   <= dist_mm;
      req_light_lux     <= lux;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      polls_sent++;
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // drop the masked buttons, hold, release, hold; a sloppy hold may fall short
   task automatic press_sequence(logic [2:0] mask, logic [15:0] dist_mm, logic [15:0] lux,
                                 bit sloppy);
      logic [2:0]  lv;
      logic [31:0] hold;
      for (int half = 0; half < 2; half++) begin
         lv = (half == 0) ? (cur_levels & ~mask) : (cur_levels | mask);
         send_poll(lv, $urandom_range(1, 40), dist_mm, lux);
         hold = sloppy ? $urandom_range(0, deb_ms) : deb_ms + 1 + $urandom_range(0, 2);
         send_poll(lv, hold, dist_mm, lux);
      end
   endtask

   function automatic logic [15:0] pick_near(logic [15:0] lo, logic [15:0] hi);
      case ($urandom_range(0, 5))
         0: return lo - 16'd1;
         1: return lo;
         2: return hi;
         3: return hi + 16'd1;
         4: return 16'($urandom_range(lo, hi));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= val;
      @(posedge clock);
   endtask

   // wait for the block to drain, then reprogram every register
   task automatic program_window(logic [7:0] deb, logic [15:0] dlo, logic [15:0] dhi,
                                 logic [15:0] llo, logic [15:0] lhi);
      req_valid <= 1'b0;
      while (results_seen != polls_sent) @(posedge clock);
      for (int k = CSR_LUX_HIGH + 1; k < (1 << CSR_INDEX_WIDTH); k++) begin
         write_reg(k[CSR_INDEX_WIDTH-1:0], 16'($urandom));
      end
      write_reg(CSR_DEBOUNCE_MS, {8'($urandom), deb});
      write_reg(CSR_DISTANCE_LOW, dlo);
      write_reg(CSR_DISTANCE_HIGH, dhi);
      write_reg(CSR_LUX_LOW, llo);
      write_reg(CSR_LUX_HIGH, lhi);
      csr_write_enable <= 1'b0;
      deb_ms  = deb;
      dist_lo = dlo;
      dist_hi = dhi;
      lux_lo  = llo;
      lux_hi  = lhi;
   endtask

   task automatic random_traffic(int count);
      int          first;
      logic [31:0] step;
      first = polls_sent;
      while (polls_sent - first < count) begin
         if ($urandom_range(0, 9) < 7) begin
            press_sequence(3'($urandom_range(1, 7)), pick_near(dist_lo, dist_hi),
                           pick_near(lux_lo, lux_hi), $urandom_range(0, 4) == 0);
         end else begin
            case ($urandom_range(0, 3))
               0: step = $urandom_range(0, deb_ms);
               1: step = 32'(deb_ms);
               2: step = 32'(deb_ms) + 32'd1;
               default: step = $urandom;
            endcase
            send_poll(3'($urandom_range(0, 7)), step, pick_near(dist_lo, dist_hi),
                      pick_near(lux_lo, lux_hi));
         end
      end
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("** debounced_posture_light_alarm_core: FAILED **");
      $finish;
   end

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_start_level   <= 1'b1;
      req_detect_level  <= 1'b1;
      req_speaker_level <= 1'b1;
      req_time_ms       <= '0;
      req_distance_mm   <= '0;
      req_light_lux     <= '0;
      csr_write_enable  <= 1'b0;
      csr_index         <= CSR_DEBOUNCE_MS;
      csr_data          <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, presses while stopped, every mode outcome
      send_poll(ALL_RELEASED, 0, 16'd0, 16'd0);
      send_poll(ALL_RELEASED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      press_sequence(PRESS_DETECT, 16'd400, 16'd500, 1'b0);
      press_sequence(PRESS_START | PRESS_SPEAKER, 16'd400, 16'd500, 1'b0);
      send_poll(cur_levels, 1, 16'd199, 16'd500);
      send_poll(cur_levels, 1, 16'd601, 16'd100);
      send_poll(cur_levels, 1, 16'd600, 16'd199);
      send_poll(cur_levels, 1, 16'd200, 16'd901);
      press_sequence(PRESS_DETECT, 16'd100, 16'd500, 1'b0);
      press_sequence(PRESS_DETECT, 16'd400, 16'd1000, 1'b0);
      press_sequence(PRESS_START | PRESS_DETECT, 16'd0, 16'd0, 1'b0);

      program_window(8'd0, 16'd200, 16'd600, 16'd200, 16'd900);
      random_traffic(80);

      receiver_stalls = 1'b0;
      program_window(8'd255, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
      random_traffic(80);

      receiver_stalls = 1'b1;
      sender_gaps     = 1'b0;
      // crossed windows: every reading is a fault
      program_window(8'($urandom_range(0, 60)), 16'd700, 16'd300, 16'd800, 16'd100);
      random_traffic(80);

      sender_gaps = 1'b1;
      program_window(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
      now_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
      random_traffic(80);

      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      program_window(8'($urandom_range(0, 40)), 16'($urandom_range(0, 500)),
                     16'($urandom_range(500, 65535)), 16'($urandom_range(0, 500)),
                     16'($urandom_range(500, 65535)));
      random_traffic(80);

      req_valid <= 1'b0;
      while (results_seen != polls_sent) @(posedge clock);
      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("** debounced_posture_light_alarm_core: PASSED **");
      end else begin
         $display("** debounced_posture_light_alarm_core: FAILED **");
      end
      $finish;
   end

endmodule

/* debounced_posture_light_alarm_core.f */
src/dpla_pkg.sv
src/dpla_debounce_lane.sv
src/dpla_merge.sv
src/debounced_posture_light_alarm_core.sv
tb/posture_alarm_checker.sv
tb/tb_debounced_posture_light_alarm_core.sv
